// File: design/tfc_pkg.sv
// Shared widths, register indexes and orientation codes for the touch coordinate mapper.
package tfc_pkg;

    localparam int PTR_W      = 16;  // pointer coordinate, signed
    localparam int DIM_W      = 14;  // window and drawable dimensions
    localparam int CNT_W      = 16;  // content dimensions
    localparam int ORI_W      = 3;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_WIDTH    = 3'd0,
        CFG_WINDOW_HEIGHT   = 3'd1,
        CFG_DRAWABLE_WIDTH  = 3'd2,
        CFG_DRAWABLE_HEIGHT = 3'd3,
        CFG_CONTENT_WIDTH   = 3'd4,
        CFG_CONTENT_HEIGHT  = 3'd5,
        CFG_ORIENTATION     = 3'd6
    } cfg_reg_t;

    typedef enum logic [ORI_W-1:0] {
        ORI_ROT_0       = 3'd0,
        ORI_ROT_90      = 3'd1,
        ORI_ROT_180     = 3'd2,
        ORI_ROT_270     = 3'd3,
        ORI_FLIP_ROT_0   = 3'd4,
        ORI_FLIP_ROT_90  = 3'd5,
        ORI_FLIP_ROT_180 = 3'd6,
        ORI_FLIP_ROT_270 = 3'd7
    } orient_t;

endpackage

// File: design/tfc_if.sv
// Valid/ready channel interfaces for pointer samples and mapped frame coordinates.
interface tfc_in_if;
    import tfc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [PTR_W-1:0] pointer_x;
    logic signed [PTR_W-1:0] pointer_y;

    modport source (output valid, output pointer_x, output pointer_y, input ready);
    modport sink   (input valid, input pointer_x, input pointer_y, output ready);
endinterface

interface tfc_out_if;
    import tfc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] frame_x;
    logic signed [OUT_W-1:0] frame_y;
    logic                    valid_res;

    modport source (output valid, output frame_x, output frame_y, output valid_res,
                    input ready);
    modport sink   (input valid, input frame_x, input frame_y, input valid_res,
                    output ready);
endinterface

// File: design/touch_to_frame_coord_map.sv
// Top level: pipelined window-to-frame pointer coordinate mapper.
//
// Pointer samples (window logical pixels) arrive on the 'pointer' channel, mapped
// frame coordinates leave on the 'frame' channel; both are valid/ready, a
// transaction completes when valid and ready are both high.
// The datapath is a fixed pipeline of 83 register stages; one transaction per
// cycle is sustained while no setup runs and the output is not stalled. The
// depth is set by the two bit-per-stage restoring dividers
// (30 stages for the HiDPI scaling, 46 for the content mapping).
// The letterbox rectangle is derived from the configuration by a sequential
// unit with one shared iterative divider: after reset and after every
// configuration write it runs, and while it runs pointer.ready is low.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// When frame.ready is low while a result is held the whole pipeline freezes and
// pointer.ready drops; nothing is lost or repeated. Reset empties the pipeline
// and restores the default registers (256 by 256 everywhere, no rotation).
// A degenerate setup (zero size anywhere) gives valid_res low with zeros.
module touch_to_frame_coord_map (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0] cfg_data,
    tfc_in_if.sink                        pointer,
    tfc_out_if.source                     frame
);
    import tfc_pkg::*;

    localparam int MAG_A_W = 2 * DIM_W + 2;          // |pointer * drawable|
    localparam int ACC_A_W = MAG_A_W + DIM_W + 1;
    localparam int MAG_B_W = MAG_A_W + CNT_W;        // |offset * content|
    localparam int ACC_B_W = MAG_B_W + DIM_W + 1;
    localparam int PRD_A_W = PTR_W + DIM_W + 1;
    localparam int PRD_B_W = MAG_B_W + 2;
    localparam int SET_W   = DIM_W + CNT_W;          // setup products
    localparam int ACC_S_W = SET_W + CNT_W + 1;
    localparam int SCNT_W  = $clog2(SET_W);

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0] ww_reg, wh_reg, dw_reg, dh_reg;
    logic [CNT_W-1:0] cw_reg, ch_reg;
    logic [ORI_W-1:0] ori_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ww_reg  <= DIM_W'(256);
            wh_reg  <= DIM_W'(256);
            dw_reg  <= DIM_W'(256);
            dh_reg  <= DIM_W'(256);
            cw_reg  <= CNT_W'(256);
            ch_reg  <= CNT_W'(256);
            ori_reg <= ORI_W'(ORI_ROT_0);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WINDOW_WIDTH:    ww_reg  <= cfg_data[DIM_W-1:0];
                CFG_WINDOW_HEIGHT:   wh_reg  <= cfg_data[DIM_W-1:0];
                CFG_DRAWABLE_WIDTH:  dw_reg  <= cfg_data[DIM_W-1:0];
                CFG_DRAWABLE_HEIGHT: dh_reg  <= cfg_data[DIM_W-1:0];
                CFG_CONTENT_WIDTH:   cw_reg  <= cfg_data[CNT_W-1:0];
                CFG_CONTENT_HEIGHT:  ch_reg  <= cfg_data[CNT_W-1:0];
                CFG_ORIENTATION:     ori_reg <= cfg_data[ORI_W-1:0];
                default:             ;
            endcase
        end
    end

    // ---------------- divider steps ----------------
    function automatic logic [ACC_A_W-1:0] step_a(logic [ACC_A_W-1:0] acc,
                                                  logic [DIM_W-1:0] d);
        logic [ACC_A_W-1:0] a;
        logic [DIM_W:0]     top;
        a   = acc << 1;
        top = a[ACC_A_W-1:MAG_A_W];
        if (top >= {1'b0, d})
        begin
            a[ACC_A_W-1:MAG_A_W] = top - {1'b0, d};
            a[0] = 1'b1;
        end
        return a;
    endfunction

    function automatic logic [ACC_B_W-1:0] step_b(logic [ACC_B_W-1:0] acc,
                                                  logic [DIM_W-1:0] d);
        logic [ACC_B_W-1:0] a;
        logic [DIM_W:0]     top;
        a   = acc << 1;
        top = a[ACC_B_W-1:MAG_B_W];
        if (top >= {1'b0, d})
        begin
            a[ACC_B_W-1:MAG_B_W] = top - {1'b0, d};
            a[0] = 1'b1;
        end
        return a;
    endfunction

    function automatic logic [ACC_S_W-1:0] step_s(logic [ACC_S_W-1:0] acc,
                                                  logic [CNT_W-1:0] d);
        logic [ACC_S_W-1:0] a;
        logic [CNT_W:0]     top;
        a   = acc << 1;
        top = a[ACC_S_W-1:SET_W];
        if (top >= {1'b0, d})
        begin
            a[ACC_S_W-1:SET_W] = top - {1'b0, d};
            a[0] = 1'b1;
        end
        return a;
    endfunction

    // ---------------- letterbox rectangle setup ----------------
    typedef enum logic [2:0] {ST_MUL, ST_DIV1, ST_DIV2, ST_FIN, ST_IDLE} setup_state_t;

    setup_state_t     state_reg;
    logic [ACC_S_W-1:0] sacc_reg;
    logic [SET_W-1:0]   p1_reg, p2_reg, q1_reg, q2_reg;
    logic [SCNT_W-1:0]  scnt_reg;
    logic [DIM_W-1:0]   rx_reg, ry_reg, rw_reg, rh_reg;
    logic               ok_reg;
    logic [ACC_S_W-1:0] sacc_next;
    logic [DIM_W-1:0]   rx_next, ry_next, rw_next, rh_next;
    logic               busy;

    always_comb
    begin
        sacc_next = step_s(sacc_reg, (state_reg == ST_DIV1) ? cw_reg : ch_reg);
        if (dh_reg == q1_reg[DIM_W-1:0] && q1_reg[SET_W-1:DIM_W] == '0
            || dw_reg == q2_reg[DIM_W-1:0] && q2_reg[SET_W-1:DIM_W] == '0)
        begin
            rx_next = '0; ry_next = '0; rw_next = dw_reg; rh_next = dh_reg;
        end
        else if (p2_reg > p1_reg)
        begin
            // height limited by width: centred vertically
            rx_next = '0;
            rw_next = dw_reg;
            rh_next = q1_reg[DIM_W-1:0];
            ry_next = (dh_reg - q1_reg[DIM_W-1:0]) >> 1;
        end
        else
        begin
            ry_next = '0;
            rh_next = dh_reg;
            rw_next = q2_reg[DIM_W-1:0];
            rx_next = (dw_reg - q2_reg[DIM_W-1:0]) >> 1;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MUL;
            scnt_reg  <= '0;
            ok_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            state_reg <= ST_MUL;
            ok_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_MUL:
                begin
                    p1_reg    <= SET_W'(dw_reg) * SET_W'(ch_reg);
                    p2_reg    <= SET_W'(dh_reg) * SET_W'(cw_reg);
                    sacc_reg  <= {{(CNT_W + 1){1'b0}}, SET_W'(dw_reg) * SET_W'(ch_reg)};
                    scnt_reg  <= '0;
                    state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (scnt_reg == SCNT_W'(SET_W - 1))
                    begin
                        q1_reg    <= sacc_next[SET_W-1:0];
                        sacc_reg  <= {{(CNT_W + 1){1'b0}}, p2_reg};
                        scnt_reg  <= '0;
                        state_reg <= ST_DIV2;
                    end
                    else
                    begin
                        scnt_reg <= scnt_reg + 1'b1;
                        sacc_reg <= sacc_next;
                    end
                end
                ST_DIV2:
                begin
                    if (scnt_reg == SCNT_W'(SET_W - 1))
                    begin
                        q2_reg    <= sacc_next[SET_W-1:0];
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        scnt_reg <= scnt_reg + 1'b1;
                        sacc_reg <= sacc_next;
                    end
                end
                ST_FIN:
                begin
                    rx_reg    <= rx_next;
                    ry_reg    <= ry_next;
                    rw_reg    <= rw_next;
                    rh_reg    <= rh_next;
                    ok_reg    <= ww_reg != '0 && wh_reg != '0 && cw_reg != '0
                                 && ch_reg != '0 && rw_next != '0 && rh_next != '0;
                    state_reg <= ST_IDLE;
                end
                ST_IDLE: ;
                default: state_reg <= ST_MUL;
            endcase
        end
    end

    // ---------------- item pipeline ----------------
    logic adv;
    logic out_valid_reg;

    assign adv           = !out_valid_reg || frame.ready;
    assign pointer.ready = adv && !busy;

    // stage 0: scale products
    logic                      v0_reg;
    logic signed [PRD_A_W-1:0] prx_reg, pry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= pointer.valid && pointer.ready;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prx_reg <= PRD_A_W'(pointer.pointer_x) * $signed(PRD_A_W'(dw_reg));
            pry_reg <= PRD_A_W'(pointer.pointer_y) * $signed(PRD_A_W'(dh_reg));
        end
    end

    // stage 1 and divider A: magnitude over window size
    logic               va_reg  [0:MAG_A_W];
    logic               sax_reg [0:MAG_A_W];
    logic               say_reg [0:MAG_A_W];
    logic [ACC_A_W-1:0] aax_reg [0:MAG_A_W];
    logic [ACC_A_W-1:0] aay_reg [0:MAG_A_W];
    logic [PRD_A_W-1:0] magx, magy;

    assign magx = prx_reg[PRD_A_W-1] ? PRD_A_W'(-prx_reg) : PRD_A_W'(prx_reg);
    assign magy = pry_reg[PRD_A_W-1] ? PRD_A_W'(-pry_reg) : PRD_A_W'(pry_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg[0] <= 1'b0;
        else if (adv)
            va_reg[0] <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sax_reg[0] <= prx_reg[PRD_A_W-1];
            say_reg[0] <= pry_reg[PRD_A_W-1];
            aax_reg[0] <= {{(DIM_W + 1){1'b0}}, magx[MAG_A_W-1:0]};
            aay_reg[0] <= {{(DIM_W + 1){1'b0}}, magy[MAG_A_W-1:0]};
        end
    end

    for (genvar k = 0; k < MAG_A_W; k++)
    begin : g_div_a
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                va_reg[k+1] <= 1'b0;
            else if (adv)
                va_reg[k+1] <= va_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sax_reg[k+1] <= sax_reg[k];
                say_reg[k+1] <= say_reg[k];
                aax_reg[k+1] <= step_a(aax_reg[k], ww_reg);
                aay_reg[k+1] <= step_a(aay_reg[k], wh_reg);
            end
        end
    end

    // stage 2: signed drawable coordinate minus rectangle origin
    logic              v2_reg;
    logic [OUT_W-1:0]  dx_reg, dy_reg;
    logic [OUT_W-1:0]  qax, qay;

    assign qax = OUT_W'(aax_reg[MAG_A_W][MAG_A_W-1:0]);
    assign qay = OUT_W'(aay_reg[MAG_A_W][MAG_A_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= va_reg[MAG_A_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= (sax_reg[MAG_A_W] ? -qax : qax) - OUT_W'(rx_reg);
            dy_reg <= (say_reg[MAG_A_W] ? -qay : qay) - OUT_W'(ry_reg);
        end
    end

    // stage 3: scale by content size
    logic                      v3_reg;
    logic signed [PRD_B_W-1:0] pbx_reg, pby_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pbx_reg <= PRD_B_W'($signed(dx_reg)) * $signed(PRD_B_W'(cw_reg));
            pby_reg <= PRD_B_W'($signed(dy_reg)) * $signed(PRD_B_W'(ch_reg));
        end
    end

    // stage 4 and divider B: magnitude over rectangle size
    logic               vb_reg  [0:MAG_B_W];
    logic               sbx_reg [0:MAG_B_W];
    logic               sby_reg [0:MAG_B_W];
    logic [ACC_B_W-1:0] abx_reg [0:MAG_B_W];
    logic [ACC_B_W-1:0] aby_reg [0:MAG_B_W];
    logic [PRD_B_W-1:0] mbx, mby;

    assign mbx = pbx_reg[PRD_B_W-1] ? PRD_B_W'(-pbx_reg) : PRD_B_W'(pbx_reg);
    assign mby = pby_reg[PRD_B_W-1] ? PRD_B_W'(-pby_reg) : PRD_B_W'(pby_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg[0] <= 1'b0;
        else if (adv)
            vb_reg[0] <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbx_reg[0] <= pbx_reg[PRD_B_W-1];
            sby_reg[0] <= pby_reg[PRD_B_W-1];
            abx_reg[0] <= {{(DIM_W + 1){1'b0}}, mbx[MAG_B_W-1:0]};
            aby_reg[0] <= {{(DIM_W + 1){1'b0}}, mby[MAG_B_W-1:0]};
        end
    end

    for (genvar k = 0; k < MAG_B_W; k++)
    begin : g_div_b
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vb_reg[k+1] <= 1'b0;
            else if (adv)
                vb_reg[k+1] <= vb_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sbx_reg[k+1] <= sbx_reg[k];
                sby_reg[k+1] <= sby_reg[k];
                abx_reg[k+1] <= step_b(abx_reg[k], rw_reg);
                aby_reg[k+1] <= step_b(aby_reg[k], rh_reg);
            end
        end
    end

    // stage 5: restore sign, wrap to 32 bits
    logic             v5_reg;
    logic [OUT_W-1:0] x_reg, y_reg;
    logic [OUT_W-1:0] qbx, qby;

    assign qbx = abx_reg[MAG_B_W][OUT_W-1:0];
    assign qby = aby_reg[MAG_B_W][OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= vb_reg[MAG_B_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= sbx_reg[MAG_B_W] ? -qbx : qbx;
            y_reg <= sby_reg[MAG_B_W] ? -qby : qby;
        end
    end

    // stage 6: orientation, output register
    logic [OUT_W-1:0] fx_next, fy_next, wmx, hmy;
    logic [OUT_W-1:0] frame_x_reg, frame_y_reg;
    logic             valid_res_reg;

    assign wmx = OUT_W'(cw_reg) - x_reg;
    assign hmy = OUT_W'(ch_reg) - y_reg;

    always_comb
    begin
        unique case (ori_reg)
            ORI_ROT_0:        begin fx_next = x_reg; fy_next = y_reg; end
            ORI_ROT_90:       begin fx_next = y_reg; fy_next = wmx;   end
            ORI_ROT_180:      begin fx_next = wmx;   fy_next = hmy;   end
            ORI_ROT_270:      begin fx_next = hmy;   fy_next = x_reg; end
            ORI_FLIP_ROT_0:   begin fx_next = wmx;   fy_next = y_reg; end
            ORI_FLIP_ROT_90:  begin fx_next = hmy;   fy_next = wmx;   end
            ORI_FLIP_ROT_180: begin fx_next = x_reg; fy_next = hmy;   end
            default:          begin fx_next = y_reg; fy_next = x_reg; end
        endcase
        if (!ok_reg)
        begin
            fx_next = '0;
            fy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frame_x_reg   <= fx_next;
            frame_y_reg   <= fy_next;
            valid_res_reg <= ok_reg;
        end
    end

    assign frame.valid     = out_valid_reg;
    assign frame.frame_x   = frame_x_reg;
    assign frame.frame_y   = frame_y_reg;
    assign frame.valid_res = valid_res_reg;

    // ---------------- assertions ----------------
    a_no_accept_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !pointer.ready)
        else $error("pointer accepted while rectangle setup runs");

    a_cfg_restarts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> state_reg == ST_MUL && !ok_reg)
        else $error("configuration write did not restart setup");

    a_invalid_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && !frame.valid_res |-> frame.frame_x == '0 && frame.frame_y == '0)
        else $error("invalid result carries non-zero coordinates");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !frame.ready |=> $stable(v5_reg) && $stable(x_reg))
        else $error("pipeline moved during output stall");

endmodule

// File: test/touch_to_frame_coord_map_tb.sv
// Testbench for the window-to-frame pointer coordinate mapper, with its own prediction.
module touch_to_frame_coord_map_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tfc_pkg::*;

    localparam int  LATENCY     = 83;
    localparam int  SETTLE      = LATENCY + 40;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  PHASES      = 12;
    localparam int  PHASE_ITEMS = 50;

    typedef struct packed {
        logic signed [OUT_W-1:0] fx;
        logic signed [OUT_W-1:0] fy;
        logic                    vres;
    } frame_res_t;

    typedef struct packed {
        logic signed [PTR_W-1:0] px;
        logic signed [PTR_W-1:0] py;
        logic                    typed;
        frame_res_t              res;
    } ptr_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tfc_in_if  pointer_ch ();
    tfc_out_if frame_ch ();

    touch_to_frame_coord_map i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pointer   (pointer_ch.sink),
        .frame     (frame_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirror of the register file
    logic [DIM_W-1:0] win_w, win_h, drw_w, drw_h;
    logic [CNT_W-1:0] cnt_w, cnt_h;
    orient_t          orient;

    frame_res_t expected_frames[$];
    int  errors = 0;
    int  results_seen = 0;
    int  invalid_seen = 0;
    int  items_sent = 0;
    int  cycles = 0;

    function automatic frame_res_t map_pointer(logic signed [PTR_W-1:0] ptr_x,
                                               logic signed [PTR_W-1:0] ptr_y);
        longint dw, dh, cw, ch, ww, wh, sx, sy, rx, ry, rw, rh;
        logic [31:0] x, y, w, h;
        frame_res_t r;
        r  = '0;
        dw = drw_w; dh = drw_h; cw = cnt_w; ch = cnt_h; ww = win_w; wh = win_h;
        if (ww == 0 || wh == 0 || cw == 0 || ch == 0)
            return r;
        sx = longint'(ptr_x) * dw / ww;
        sy = longint'(ptr_y) * dh / wh;
        if (dh == dw * ch / cw || dw == dh * cw / ch)
        begin
            rx = 0; ry = 0; rw = dw; rh = dh;
        end
        else if (cw * dh > ch * dw)
        begin
            rx = 0; rw = dw; rh = dw * ch / cw; ry = (dh - rh) / 2;
        end
        else
        begin
            ry = 0; rh = dh; rw = dh * cw / ch; rx = (dw - rw) / 2;
        end
        if (rw == 0 || rh == 0)
            return r;
        x = 32'((sx - rx) * cw / rw);
        y = 32'((sy - ry) * ch / rh);
        w = 32'(cw);
        h = 32'(ch);
        case (orient)
            ORI_ROT_0:        begin r.fx = x;     r.fy = y;     end
            ORI_ROT_90:       begin r.fx = y;     r.fy = w - x; end
            ORI_ROT_180:      begin r.fx = w - x; r.fy = h - y; end
            ORI_ROT_270:      begin r.fx = h - y; r.fy = x;     end
            ORI_FLIP_ROT_0:   begin r.fx = w - x; r.fy = y;     end
            ORI_FLIP_ROT_90:  begin r.fx = h - y; r.fy = w - x; end
            ORI_FLIP_ROT_180: begin r.fx = x;     r.fy = h - y; end
            default:          begin r.fx = y;     r.fy = x;     end
        endcase
        r.vres = 1'b1;
        return r;
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_WINDOW_WIDTH:    win_w  = val[DIM_W-1:0];
            CFG_WINDOW_HEIGHT:   win_h  = val[DIM_W-1:0];
            CFG_DRAWABLE_WIDTH:  drw_w  = val[DIM_W-1:0];
            CFG_DRAWABLE_HEIGHT: drw_h  = val[DIM_W-1:0];
            CFG_CONTENT_WIDTH:   cnt_w  = val;
            CFG_CONTENT_HEIGHT:  cnt_h  = val;
            default:             orient = orient_t'(val[ORI_W-1:0]);
        endcase
    endtask

    task automatic write_all(int ww, int wh, int dw, int dh, int cw, int ch, int ori);
        write_reg(CFG_WINDOW_WIDTH, CFG_DATA_W'(ww));
        write_reg(CFG_WINDOW_HEIGHT, CFG_DATA_W'(wh));
        write_reg(CFG_DRAWABLE_WIDTH, CFG_DATA_W'(dw));
        write_reg(CFG_DRAWABLE_HEIGHT, CFG_DATA_W'(dh));
        write_reg(CFG_CONTENT_WIDTH, CFG_DATA_W'(cw));
        write_reg(CFG_CONTENT_HEIGHT, CFG_DATA_W'(ch));
        write_reg(CFG_ORIENTATION, CFG_DATA_W'(ori));
    endtask

    // hold valid through a burst; payload changes only at the falling edge
    task automatic send_pointer(logic signed [PTR_W-1:0] ptr_x,
                                logic signed [PTR_W-1:0] ptr_y,
                                bit typed, frame_res_t typed_res);
        @(negedge clk);
        pointer_ch.valid     <= 1'b1;
        pointer_ch.pointer_x <= ptr_x;
        pointer_ch.pointer_y <= ptr_y;
        do @(posedge clk); while (!pointer_ch.ready);
        expected_frames.push_back(typed ? typed_res : map_pointer(ptr_x, ptr_y));
        items_sent++;
    endtask

    int burst_left = 0;
    task automatic maybe_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
        if ($urandom_range(0, 1))
        begin
            @(negedge clk);
            pointer_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        pointer_ch.valid <= 1'b0;
        wait (expected_frames.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int rand_dim(int maxv);
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return maxv;
            2:       return $urandom_range(1, maxv);
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    // receiver: stall density changes from run to run, sometimes none at all
    int stall_pct = 0;
    int stall_run = 0;
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run = $urandom_range(10, 80);
            stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 75);
        end
        stall_run--;
        frame_ch.ready <= !rst_n ? 1'b0 : ($urandom_range(1, 100) > stall_pct);
    end

    always @(posedge clk)
    begin
        frame_res_t exp_res;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("touch_to_frame_coord_map_tb NOT OK");
            $finish;
        end
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            results_seen++;
            if (!frame_ch.valid_res)
                invalid_seen++;
            if (expected_frames.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: x=%0d y=%0d v=%0b",
                             frame_ch.frame_x, frame_ch.frame_y, frame_ch.valid_res);
            end
            else
            begin
                exp_res = expected_frames.pop_front();
                if (frame_ch.frame_x !== exp_res.fx || frame_ch.frame_y !== exp_res.fy ||
                    frame_ch.valid_res !== exp_res.vres)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch #%0d: exp x=%0d y=%0d v=%0b got x=%0d y=%0d v=%0b",
                                 results_seen, exp_res.fx, exp_res.fy, exp_res.vres,
                                 frame_ch.frame_x, frame_ch.frame_y, frame_ch.valid_res);
                end
            end
        end
    end

    // under the reset setup the mapping is the identity, sign-extended
    ptr_row_t reset_rows[6] = '{
        '{16'sh0000, 16'sh0000, 1'b1, '{32'sd0, 32'sd0, 1'b1}},
        '{16'sh7FFF, 16'sh7FFF, 1'b1, '{32'sd32767, 32'sd32767, 1'b1}},
        '{16'sh8000, 16'sh8000, 1'b1, '{-32'sd32768, -32'sd32768, 1'b1}},
        '{16'sh7FFF, 16'sh8000, 1'b1, '{32'sd32767, -32'sd32768, 1'b1}},
        '{16'shFFFF, 16'sh0001, 1'b1, '{-32'sd1, 32'sd1, 1'b1}},
        '{16'sh00FF, 16'sh0080, 1'b1, '{32'sd255, 32'sd128, 1'b1}}
    };

    initial
    begin
        int ori;
        int i;
        int ph;
        frame_res_t zero_res;
        logic signed [PTR_W-1:0] rx_in, ry_in;
        zero_res = '0;
        pointer_ch.valid     = 1'b0;
        pointer_ch.pointer_x = '0;
        pointer_ch.pointer_y = '0;
        win_w = 256; win_h = 256; drw_w = 256; drw_h = 256;
        cnt_w = 256; cnt_h = 256; orient = ORI_ROT_0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (reset_rows[k])
            send_pointer(reset_rows[k].px, reset_rows[k].py, reset_rows[k].typed,
                         reset_rows[k].res);
        drain();

        // every orientation on a letterboxed setup
        for (ori = 0; ori < 8; ori++)
        begin
            write_all(640, 480, 1280, 960, 300, 700, ori);
            send_pointer(16'sd320, 16'sd240, 1'b0, zero_res);
            drain();
        end

        // degenerate setups: zero window, zero content, zero-size rectangle
        write_all(0, 480, 1280, 960, 300, 700, 0);
        send_pointer(16'sd10, 16'sd10, 1'b1, zero_res);
        drain();
        write_all(640, 480, 1280, 960, 0, 700, 0);
        send_pointer(16'sd10, 16'sd10, 1'b1, zero_res);
        drain();
        write_all(640, 480, 0, 960, 300, 700, 0);
        send_pointer(16'sd10, 16'sd10, 1'b1, zero_res);
        drain();
        // largest drawable size and content width, wrapping coordinates
        write_all(1, 1, 16383, 16383, 65535, 1, 5);
        send_pointer(16'sh7FFF, 16'sh8000, 1'b0, zero_res);
        send_pointer(16'sh8000, 16'sh7FFF, 1'b0, zero_res);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_all(rand_dim(16383), rand_dim(16383), rand_dim(16383), rand_dim(16383),
                      rand_dim(65535), rand_dim(65535), $urandom_range(0, 7));
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    rx_in = PTR_W'($urandom_range(0, win_w));
                    ry_in = PTR_W'($urandom_range(0, win_h));
                end
                else
                begin
                    rx_in = PTR_W'($urandom);
                    ry_in = PTR_W'($urandom);
                end
                send_pointer(rx_in, ry_in, 1'b0, zero_res);
                maybe_gap();
            end
            drain();
        end

        $display("sent %0d pointer transactions over %0d register setups", items_sent,
                 PHASES + 13);
        $display("checked %0d results, %0d of them flagged invalid", results_seen,
                 invalid_seen);
        if (errors == 0 && expected_frames.size() == 0)
            $display("touch_to_frame_coord_map_tb OK");
        else
            $display("touch_to_frame_coord_map_tb NOT OK");
        $finish;
    end
endmodule

// File: sim.f
design/tfc_pkg.sv
design/tfc_if.sv
design/touch_to_frame_coord_map.sv
test/touch_to_frame_coord_map_tb.sv
